// ===== rtl/hot_key_counter_table_core_macros.svh =====
// assertion macros for the hot key counter table core
// used by hot_key_counter_table_core.sv, no other dependencies
`ifndef HOT_KEY_COUNTER_TABLE_CORE_MACROS_SVH
`define HOT_KEY_COUNTER_TABLE_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HKCT_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hkct assertion failed");

// next-cycle implication, disabled while in reset
`define HKCT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hkct assertion failed");

`endif

// ===== rtl/hkct_pkg.sv =====
// shared types and constants for the hot key counter table core
// no dependencies
package hkct_pkg;

    localparam int KEY_W         = 64;
    localparam int STEP_W        = 48;
    localparam int COUNT_W       = 32;
    localparam int SLOT_OUT_W    = 12;
    localparam int TABLE_ENTRIES = 4096;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
    localparam int PROBE_LIMIT   = 8;
    localparam int PROBE_W       = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
    localparam int HASH_SHIFT    = 3;

    localparam int S_TDATA_W     = ((KEY_W + STEP_W + 7) / 8) * 8;
    localparam int M_TDATA_W     = ((COUNT_W + SLOT_OUT_W + 7) / 8) * 8;
    localparam int M_TUSER_W     = 3;

    localparam int APB_DATA_W    = 64;
    localparam int PADDR_W       = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = COUNT_W'(2);

    typedef enum logic {
        REG_THRESHOLD = 1'b0,
        REG_DEFER     = 1'b1
    } reg_sel_t;

    typedef enum logic [M_TUSER_W-1:0] {
        OUT_DEFERRED = 3'd0,
        OUT_INSERTED = 3'd1,
        OUT_COUNTED  = 3'd2,
        OUT_HOT      = 3'd3,
        OUT_DROPPED  = 3'd4
    } outcome_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] threshold;
        logic [STEP_W-1:0]  defer;
    } cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [KEY_W-1:0]   key;
    } entry_t;

endpackage

// ===== rtl/hot_key_counter_table_core.sv =====
// hot key counter table core: one transaction in, one result transaction out.
// each event is looked up by a probe loop that issues one read per probe, up to 8 probes,
// to the single table ram; a deferred event skips the probe loop. a new event is taken only
// once the last result has moved into the output register, which can wait on m_tready.
// reset: synchronous active low; a clearing sweep of all 4096 table entries follows,
// with s_tready low; configuration writes are taken throughout.
`include "hot_key_counter_table_core_macros.svh"
module hot_key_counter_table_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // method_key [63:0], step_count [111:64]
    input  logic [hkct_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // outcome [2:0]
    output logic [hkct_pkg::M_TUSER_W-1:0]   m_tuser,
    // count_value [31:0], slot_index [43:32], zero [47:44]
    output logic [hkct_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hkct_pkg::PADDR_W-1:0]     paddr,
    input  logic [hkct_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [hkct_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import hkct_pkg::*;

    cfg_t               cfg;
    outcome_t           out_outcome;
    logic [COUNT_W-1:0] out_count;
    logic [SLOT_W-1:0]  out_slot;
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    entry_t             ram_wdata;
    logic               ram_re;
    logic [SLOT_W-1:0]  ram_raddr;
    entry_t             ram_rdata;

    hkct_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hkct_probe u_probe (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .in_key      (s_tdata[KEY_W-1:0]),
        .in_step     (s_tdata[KEY_W +: STEP_W]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_outcome (out_outcome),
        .out_count   (out_count),
        .out_slot    (out_slot),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    hkct_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH ($bits(entry_t))
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tuser = out_outcome;
    assign m_tdata = M_TDATA_W'({SLOT_OUT_W'(out_slot), out_count});

    // one event in flight at a time
    `HKCT_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // table writes never coincide with an input accept
    `HKCT_ASSERT_SAME(a_no_write_on_accept, aclk, aresetn, ram_we, !(s_tvalid && s_tready))

    // deferred and dropped results carry zero count and slot
    `HKCT_ASSERT_SAME(a_zero_payload, aclk, aresetn,
        m_tvalid && (m_tuser == OUT_DEFERRED || m_tuser == OUT_DROPPED), m_tdata == '0)

    // an insertion always reports a count of one
    `HKCT_ASSERT_SAME(a_insert_count, aclk, aresetn,
        m_tvalid && (m_tuser == OUT_INSERTED), m_tdata[COUNT_W-1:0] == COUNT_W'(1))

endmodule

// ===== rtl/hkct_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module hkct_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 96
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/hkct_regs.sv =====
// apb configuration registers: hot threshold and step deferral
// depends on hkct_pkg
module hkct_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hkct_pkg::PADDR_W-1:0]   paddr,
    input  logic [hkct_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hkct_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output hkct_pkg::cfg_t                 cfg
);
    import hkct_pkg::*;

    logic [COUNT_W-1:0] threshold_reg, threshold_next;
    logic [STEP_W-1:0]  defer_reg, defer_next;
    reg_sel_t           sel;
    logic               wr_en;

    assign sel    = reg_sel_t'(paddr[3]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_comb begin
        threshold_next = threshold_reg;
        defer_next     = defer_reg;
        if (wr_en) begin
            unique case (sel)
                REG_THRESHOLD: threshold_next = pwdata[COUNT_W-1:0];
                REG_DEFER:     defer_next     = pwdata[STEP_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_THRESHOLD: prdata = APB_DATA_W'(threshold_reg);
            REG_DEFER:     prdata = APB_DATA_W'(defer_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            defer_reg     <= '0;
        end else begin
            threshold_reg <= threshold_next;
            defer_reg     <= defer_next;
        end
    end

    assign cfg.threshold = threshold_reg;
    assign cfg.defer     = defer_reg;

endmodule

// ===== rtl/hkct_probe.sv =====
// probe engine: clearing sweep, linear probe read-modify-write, result register
// depends on hkct_pkg; drives the table ram in the top level
module hkct_probe (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  hkct_pkg::cfg_t                    cfg,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [hkct_pkg::KEY_W-1:0]        in_key,
    input  logic [hkct_pkg::STEP_W-1:0]       in_step,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output hkct_pkg::outcome_t                out_outcome,
    output logic [hkct_pkg::COUNT_W-1:0]      out_count,
    output logic [hkct_pkg::SLOT_W-1:0]       out_slot,
    output logic                              ram_we,
    output logic [hkct_pkg::SLOT_W-1:0]       ram_waddr,
    output hkct_pkg::entry_t                  ram_wdata,
    output logic                              ram_re,
    output logic [hkct_pkg::SLOT_W-1:0]       ram_raddr,
    input  hkct_pkg::entry_t                  ram_rdata
);
    import hkct_pkg::*;

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [SLOT_W-1:0]  addr_reg, addr_next;
    logic [PROBE_W-1:0] probe_reg, probe_next;
    outcome_t           res_outcome_reg, res_outcome_next;
    logic [COUNT_W-1:0] res_count_reg, res_count_next;
    logic [SLOT_W-1:0]  res_slot_reg, res_slot_next;
    logic               m_valid_reg, m_valid_next;
    outcome_t           m_outcome_reg, m_outcome_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;
    logic [SLOT_W-1:0]  m_slot_reg, m_slot_next;

    logic [COUNT_W-1:0] thr_eff;
    logic [COUNT_W-1:0] count_inc;
    logic [SLOT_W-1:0]  home;
    logic [SLOT_W-1:0]  addr_inc;
    logic               deferred;
    logic               hit;
    logic               empty;
    logic               last_probe;

    assign thr_eff    = (cfg.threshold == '0) ? COUNT_W'(1) : cfg.threshold;
    assign count_inc  = ram_rdata.count + COUNT_W'(1);
    assign home       = in_key[HASH_SHIFT +: SLOT_W];
    assign addr_inc   = addr_reg + SLOT_W'(1);
    assign deferred   = (cfg.defer != '0) && (in_step < cfg.defer);
    assign hit        = (ram_rdata.key == key_reg);
    assign empty      = (ram_rdata.key == '0);
    assign last_probe = (probe_reg == PROBE_W'(PROBE_LIMIT - 1));

    always_comb begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        key_next         = key_reg;
        addr_next        = addr_reg;
        probe_next       = probe_reg;
        res_outcome_next = res_outcome_reg;
        res_count_next   = res_count_reg;
        res_slot_next    = res_slot_reg;
        m_valid_next     = m_valid_reg & ~m_tready;
        m_outcome_next   = m_outcome_reg;
        m_count_next     = m_count_reg;
        m_slot_next      = m_slot_reg;
        s_tready         = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = addr_reg;
        ram_wdata        = '0;
        ram_re           = 1'b0;
        ram_raddr        = home;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + SLOT_W'(1);
                if (clr_addr_reg == SLOT_W'(TABLE_ENTRIES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    key_next   = in_key;
                    addr_next  = home;
                    probe_next = '0;
                    ram_re     = 1'b1;
                    if (deferred) begin
                        res_outcome_next = OUT_DEFERRED;
                        res_count_next   = '0;
                        res_slot_next    = '0;
                        state_next       = ST_EMIT;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                priority if (hit) begin
                    res_slot_next = addr_reg;
                    state_next    = ST_EMIT;
                    if (ram_rdata.count == COUNT_MAX) begin
                        res_outcome_next = OUT_COUNTED;
                        res_count_next   = ram_rdata.count;
                    end else begin
                        ram_we           = 1'b1;
                        ram_wdata.key    = key_reg;
                        ram_wdata.count  = count_inc;
                        res_count_next   = count_inc;
                        res_outcome_next = (count_inc == thr_eff) ? OUT_HOT : OUT_COUNTED;
                    end
                end else if (empty) begin
                    ram_we           = 1'b1;
                    ram_wdata.key    = key_reg;
                    ram_wdata.count  = COUNT_W'(1);
                    res_outcome_next = OUT_INSERTED;
                    res_count_next   = COUNT_W'(1);
                    res_slot_next    = addr_reg;
                    state_next       = ST_EMIT;
                end else if (last_probe) begin
                    res_outcome_next = OUT_DROPPED;
                    res_count_next   = '0;
                    res_slot_next    = '0;
                    state_next       = ST_EMIT;
                end else begin
                    addr_next  = addr_inc;
                    probe_next = probe_reg + PROBE_W'(1);
                    ram_re     = 1'b1;
                    ram_raddr  = addr_inc;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    m_outcome_next = res_outcome_reg;
                    m_count_next   = res_count_reg;
                    m_slot_next    = res_slot_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg         <= key_next;
        addr_reg        <= addr_next;
        probe_reg       <= probe_next;
        res_outcome_reg <= res_outcome_next;
        res_count_reg   <= res_count_next;
        res_slot_reg    <= res_slot_next;
        m_outcome_reg   <= m_outcome_next;
        m_count_reg     <= m_count_next;
        m_slot_reg      <= m_slot_next;
    end

    assign m_tvalid    = m_valid_reg;
    assign out_outcome = m_outcome_reg;
    assign out_count   = m_count_reg;
    assign out_slot    = m_slot_reg;

endmodule

// ===== verif/hot_key_table_checker.sv =====
`timescale 1ns / 1ps
// checker for the hot key counter table core: mirrors the probe table and register file,
// predicts every result transaction and compares it field by field, checks register reads
// depends on hkct_pkg
module hot_key_table_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [hkct_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [hkct_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic [hkct_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hkct_pkg::PADDR_W-1:0]     paddr,
    input  logic [hkct_pkg::APB_DATA_W-1:0]  pwdata,
    input  logic [hkct_pkg::APB_DATA_W-1:0]  prdata,
    input  logic                             pready,
    output int                               mismatches,
    output int                               outstanding
);
    import hkct_pkg::*;

    typedef struct packed {
        outcome_t                outcome;
        logic [COUNT_W-1:0]      count;
        logic [SLOT_OUT_W-1:0]   slot;
    } hot_result_t;

    logic [KEY_W-1:0]   slot_keys   [TABLE_ENTRIES];
    logic [COUNT_W-1:0] slot_counts [TABLE_ENTRIES];
    logic [COUNT_W-1:0] threshold_cfg;
    logic [STEP_W-1:0]  defer_cfg;
    hot_result_t        expected_results [$];

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            slot_keys[i]   = '0;
            slot_counts[i] = '0;
        end
        threshold_cfg = THRESHOLD_RESET;
        defer_cfg     = '0;
        mismatches    = 0;
        outstanding   = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch on %s: got %0h expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // linear probe from the home slot, match test before empty test
    function automatic hot_result_t tally_method_event(input logic [KEY_W-1:0] key,
                                                       input logic [STEP_W-1:0] step);
        hot_result_t        r;
        logic [COUNT_W-1:0] hot_at;
        logic [SLOT_W-1:0]  slot;
        bit                 saturated;
        bit                 settled;
        int                 p;
        r.outcome = OUT_DROPPED;
        r.count   = '0;
        r.slot    = '0;
        hot_at    = (threshold_cfg == '0) ? COUNT_W'(1) : threshold_cfg;
        if (defer_cfg != '0 && step < defer_cfg) begin
            r.outcome = OUT_DEFERRED;
            return r;
        end
        settled = 1'b0;
        for (p = 0; p < PROBE_LIMIT && !settled; p++) begin
            slot = key[HASH_SHIFT +: SLOT_W] + SLOT_W'(p);
            if (slot_keys[slot] == key) begin
                saturated = (slot_counts[slot] == COUNT_MAX);
                if (!saturated)
                    slot_counts[slot] = slot_counts[slot] + 1'b1;
                r.outcome = (!saturated && slot_counts[slot] == hot_at) ? OUT_HOT : OUT_COUNTED;
                r.count   = slot_counts[slot];
                r.slot    = slot;
                settled   = 1'b1;
            end else if (slot_keys[slot] == '0) begin
                slot_keys[slot]   = key;
                slot_counts[slot] = COUNT_W'(1);
                r.outcome = OUT_INSERTED;
                r.count   = COUNT_W'(1);
                r.slot    = slot;
                settled   = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        hot_result_t             want;
        logic [APB_DATA_W-1:0]   reg_value;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 64'(m_tdata), 64'(m_tuser));
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.outcome)
                        report_mismatch("outcome", 64'(m_tuser), 64'(want.outcome));
                    if (m_tdata[COUNT_W-1:0] !== want.count)
                        report_mismatch("count_value", 64'(m_tdata[COUNT_W-1:0]),
                                        64'(want.count));
                    if (m_tdata[COUNT_W +: SLOT_OUT_W] !== want.slot)
                        report_mismatch("slot_index", 64'(m_tdata[COUNT_W +: SLOT_OUT_W]),
                                        64'(want.slot));
                    if (m_tdata[M_TDATA_W-1:COUNT_W+SLOT_OUT_W] !== '0)
                        report_mismatch("tdata padding",
                                        64'(m_tdata[M_TDATA_W-1:COUNT_W+SLOT_OUT_W]), 64'(0));
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(tally_method_event(s_tdata[KEY_W-1:0],
                                                              s_tdata[KEY_W +: STEP_W]));
            if (psel && penable && pready && paddr[2:0] == 3'b000) begin
                case (reg_sel_t'(paddr[3]))
                    REG_THRESHOLD: begin
                        reg_value = APB_DATA_W'(threshold_cfg);
                        if (pwrite)
                            threshold_cfg = pwdata[COUNT_W-1:0];
                    end
                    default: begin
                        reg_value = APB_DATA_W'(defer_cfg);
                        if (pwrite)
                            defer_cfg = pwdata[STEP_W-1:0];
                    end
                endcase
                if (!pwrite && prdata !== reg_value)
                    report_mismatch("register read", prdata, reg_value);
            end
        end
        outstanding <= expected_results.size();
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// top of the hot key counter table core testbench: clock, reset, register programming
// and event stimulus; prediction and comparison live in hot_key_table_checker
// depends on hkct_pkg, hot_key_table_checker and hot_key_counter_table_core
module tb_top;
    import hkct_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 135;
    localparam int POOL_HOMES  = 5;
    localparam int POOL_KEYS   = 50;
    localparam logic [STEP_W-1:0] STEP_MAX = '1;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TUSER_W-1:0]    m_tuser;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    int                      mismatches;
    int                      outstanding;
    int                      cycles = 0;
    int                      valid_idle_pct;
    int                      ready_idle_pct;

    logic [KEY_W-1:0]   key_pool [POOL_KEYS];
    logic [COUNT_W-1:0] phase_threshold [PHASES] =
        '{32'd2, 32'd1, 32'hFFFF_FFFF, 32'd4, 32'd3, 32'd2};
    logic [STEP_W-1:0]  phase_defer [PHASES] =
        '{48'd0, 48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'd1, 48'd0, 48'd0};
    int phase_valid_idle [PHASES] = '{14, 14, 69, 69, 0, 0};
    int phase_ready_idle [PHASES] = '{69, 69, 14, 14, 0, 0};

    hot_key_counter_table_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    hot_key_table_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= ready_idle_pct);
    end

    // setup then access; back-to-back transfers keep psel high
    task automatic apb_access(input bit is_write, input reg_sel_t sel,
                              input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= PADDR_W'({sel, 3'b000});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    task automatic program_table(input logic [COUNT_W-1:0] threshold,
                                 input logic [STEP_W-1:0] defer);
        apb_access(1'b1, REG_THRESHOLD, APB_DATA_W'(threshold));
        apb_access(1'b0, REG_THRESHOLD, '0);
        apb_access(1'b1, REG_DEFER, APB_DATA_W'(defer));
        apb_access(1'b0, REG_DEFER, '0);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_event(input logic [KEY_W-1:0] key, input logic [STEP_W-1:0] step);
        if ($urandom_range(0, 99) < valid_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < valid_idle_pct)
                @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {step, key};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    function automatic logic [STEP_W-1:0] random_step(input logic [STEP_W-1:0] defer);
        logic [63:0] raw;
        logic [63:0] span;
        int          pick;
        raw  = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        span = 64'(STEP_MAX) - 64'(defer) + 64'd1;
        if (pick < 5)
            return STEP_MAX;
        if (pick < 10)
            return '0;
        if (defer != '0 && pick < 15)
            return defer - 1'b1;
        if (pick < 20)
            return defer;
        if (defer != '0 && pick < 40)
            return STEP_W'(raw % 64'(defer));
        return STEP_W'(64'(defer) + raw % span);
    endfunction

    // mostly keys that pile up on a few home slots, some noise
    function automatic logic [KEY_W-1:0] random_key();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return key_pool[$urandom_range(0, POOL_KEYS - 1)];
        if (pick < 93)
            return {$urandom, $urandom};
        if (pick < 96)
            return '0;
        if (pick < 98)
            return '1;
        return KEY_W'($urandom_range(1, 7));
    endfunction

    initial begin
        logic [SLOT_W-1:0] homes [POOL_HOMES];
        logic [KEY_W-1:0]  clash_key;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        valid_idle_pct = 14;
        ready_idle_pct = 69;
        aresetn        = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int h = 0; h < POOL_HOMES; h++)
            homes[h] = SLOT_W'($urandom_range(200, TABLE_ENTRIES - 16));
        for (int i = 0; i < POOL_KEYS; i++) begin
            key_pool[i] = {$urandom, $urandom};
            key_pool[i][HASH_SHIFT +: SLOT_W] = homes[i % POOL_HOMES];
        end
        phase_defer[4] = STEP_W'({$urandom, $urandom});

        program_table(32'd3, '0);
        // count up through the threshold and past it
        push_event(64'd1, '0);
        push_event(64'd1, STEP_MAX);
        push_event(64'd1, STEP_W'({$urandom, $urandom}));
        push_event(64'd1, '0);
        // zero key counts on the first empty slot without claiming it
        push_event(64'd0, STEP_MAX);
        push_event(64'd0, '0);
        push_event(64'd0, STEP_W'({$urandom, $urandom}));
        push_event(64'd8, '0);
        // home at the last slot, then a wrap past the table end
        push_event('1, STEP_MAX);
        push_event(64'h7FFF_FFFF_FFFF_FFFF, '0);
        // nine keys on one home slot: the ninth falls outside the probe window
        for (int j = 0; j < 9; j++) begin
            clash_key = (64'd100 << HASH_SHIFT) | (64'(j) << (HASH_SHIFT + SLOT_W));
            if (j[0])
                clash_key[KEY_W-1] = 1'b1;
            push_event(clash_key, STEP_W'({$urandom, $urandom}));
        end
        push_event((64'd100 << HASH_SHIFT) | (64'd3 << (HASH_SHIFT + SLOT_W)) | 64'h8000_0000_0000_0000,
                   STEP_MAX);
        push_event(64'hAAAA_AAAA_5555_5555, 48'h5555_AAAA_5555);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            valid_idle_pct = phase_valid_idle[ph];
            ready_idle_pct = phase_ready_idle[ph];
            program_table(phase_threshold[ph], phase_defer[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == 60)
                    wait_drained();
                push_event(random_key(), random_step(phase_defer[ph]));
            end
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hkct_pkg.sv
rtl/hkct_ram.sv
rtl/hkct_regs.sv
rtl/hkct_probe.sv
rtl/hot_key_counter_table_core.sv
verif/hot_key_table_checker.sv
verif/tb_top.sv
